// ----- hw/rtl/odg_pkg.sv -----
// ============================================================================
// odg_pkg - shared types, constants and tables of the odometry gate
// Widths of the pose and step fields, the fixed-point angle constants, the
// arctangent table of the rotation chain and the record that moves through it.
// ============================================================================
`default_nettype none

package odg_pkg;

  // Rotation chain length and arctangent table size.
  localparam int ROTATION_STAGES = 16;
  localparam int ATAN_LEN        = 24;
  localparam int CELLS           = (ROTATION_STAGES < ATAN_LEN) ? ROTATION_STAGES : ATAN_LEN;
  localparam int STAGE_W         = $clog2(ATAN_LEN);

  // Field widths.
  localparam int POS_W   = 32;           // Q16.16 position
  localparam int HEAD_W  = 16;           // Q4.12 heading
  localparam int DIFF_W  = POS_W + 1;    // exact position difference
  localparam int ANGLE_W = HEAD_W + 2;   // exact heading difference
  localparam int TURN_W  = 17;           // reported heading change
  localparam int LIM_W   = 31;           // distance limit
  localparam int HLIM_W  = 15;           // heading limit
  localparam int SQ_W    = 2 * LIM_W;    // square of a 31-bit magnitude
  localparam int XY_W    = 31;           // rotation vector, Q.28
  localparam int Z_W     = 28;           // residual angle, Q.24

  // Configuration port.
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DISTANCE_LIMIT = 4'd0,
    REG_HEADING_LIMIT  = 4'd1
  } cfg_reg_t;

  localparam logic [LIM_W-1:0]  DISTANCE_LIMIT_RESET = 31'd13107;
  localparam logic [HLIM_W-1:0] HEADING_LIMIT_RESET  = 15'd819;

  // Angles in Q4.12.
  localparam logic signed [ANGLE_W-1:0] PI_Q          = 18'sd12868;
  localparam logic signed [ANGLE_W-1:0] NEG_PI_Q      = -18'sd12868;
  localparam logic signed [ANGLE_W-1:0] TWO_PI_Q      = 18'sd25736;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q     = 18'sd6434;
  localparam logic signed [ANGLE_W-1:0] NEG_HALF_PI_Q = -18'sd6434;

  // Start value of the rotation: inverse of the infinite-stage gain, Q.28.
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 31'sd163008219;

  // Record carried from cell to cell.
  typedef struct packed {
    logic                     valid;
    logic                     moved;
    logic                     flip;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [TURN_W-1:0] turn;
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [Z_W-1:0]    z;
  } odg_cell_t;

  // atan(2^-i) in Q.24.
  function automatic logic signed [Z_W-1:0] atan_q24(input logic [STAGE_W-1:0] idx);
    logic signed [Z_W-1:0] a;
    case (idx)
      5'd0:    a = Z_W'(13176795);
      5'd1:    a = Z_W'(7778716);
      5'd2:    a = Z_W'(4110060);
      5'd3:    a = Z_W'(2086331);
      5'd4:    a = Z_W'(1047214);
      5'd5:    a = Z_W'(524117);
      5'd6:    a = Z_W'(262123);
      5'd7:    a = Z_W'(131069);
      5'd8:    a = Z_W'(65536);
      5'd9:    a = Z_W'(32768);
      5'd10:   a = Z_W'(16384);
      5'd11:   a = Z_W'(8192);
      5'd12:   a = Z_W'(4096);
      5'd13:   a = Z_W'(2048);
      5'd14:   a = Z_W'(1024);
      5'd15:   a = Z_W'(512);
      5'd16:   a = Z_W'(256);
      5'd17:   a = Z_W'(128);
      5'd18:   a = Z_W'(64);
      5'd19:   a = Z_W'(32);
      5'd20:   a = Z_W'(16);
      5'd21:   a = Z_W'(8);
      5'd22:   a = Z_W'(4);
      5'd23:   a = Z_W'(2);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/odg_cell.sv -----
// ============================================================================
// odg_cell - one micro-rotation of the heading rotation chain
// Rotates the carried vector by +/- atan(2^-stage) toward a zero residual
// angle and registers the result together with the item's payload.
// ============================================================================
`default_nettype none

module odg_cell
  import odg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               enable,
  input  wire logic [STAGE_W-1:0] stage,
  input  wire odg_cell_t          cin,
  output odg_cell_t               cout
);

  logic signed [XY_W-1:0] x;
  logic signed [XY_W-1:0] y;
  logic signed [Z_W-1:0]  z;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  a;
  odg_cell_t              cout_next;

  always_comb begin
    x  = cin.x;
    y  = cin.y;
    z  = cin.z;
    xs = x >>> stage;
    ys = y >>> stage;
    a  = atan_q24(stage);
    cout_next = cin;
    if (!z[Z_W-1]) begin
      cout_next.x = x - ys;
      cout_next.y = y + xs;
      cout_next.z = z - a;
    end else begin
      cout_next.x = x + ys;
      cout_next.y = y - xs;
      cout_next.z = z + a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout.valid <= 1'b0;
    end else if (enable) begin
      cout <= cout_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/odg_gate.sv -----
// ============================================================================
// odg_gate - displacement threshold decision and last-pose register
// Forms the differences of each pose against both possible last poses, picks
// the right one once the item ahead has decided, and starts the rotation.
// ============================================================================
`default_nettype none

module odg_gate
  import odg_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     enable,
  input  wire logic                     in_valid,
  input  wire logic signed [POS_W-1:0]  pose_x,
  input  wire logic signed [POS_W-1:0]  pose_y,
  input  wire logic signed [HEAD_W-1:0] pose_heading,
  input  wire logic [SQ_W-1:0]          lim_sq,
  input  wire logic [HLIM_W-1:0]        heading_limit,
  output odg_cell_t                     cell_in
);

  typedef struct packed {
    logic                     big;
    logic                     hturn;
    logic [SQ_W-1:0]          sqx;
    logic [SQ_W-1:0]          sqy;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [TURN_W-1:0] turn;
  } cand_t;

  // Differences of a pose against one reference pose.
  function automatic cand_t diff_pose(
    input logic signed [POS_W-1:0]  px,
    input logic signed [POS_W-1:0]  py,
    input logic signed [HEAD_W-1:0] ph,
    input logic signed [POS_W-1:0]  rx,
    input logic signed [POS_W-1:0]  ry,
    input logic signed [HEAD_W-1:0] rh,
    input logic [HLIM_W-1:0]        hlim
  );
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [ANGLE_W-1:0] da;
    logic [DIFF_W-1:0]         ax;
    logic [DIFF_W-1:0]         ay;
    logic [ANGLE_W-1:0]        ad;
    cand_t                     c;
    dx = {px[POS_W-1], px} - {rx[POS_W-1], rx};
    dy = {py[POS_W-1], py} - {ry[POS_W-1], ry};
    da = {{2{ph[HEAD_W-1]}}, ph} - {{2{rh[HEAD_W-1]}}, rh};
    if (da > PI_Q) da = da - TWO_PI_Q;
    if (da < NEG_PI_Q) da = da + TWO_PI_Q;
    ax = dx[DIFF_W-1] ? -dx : dx;
    ay = dy[DIFF_W-1] ? -dy : dy;
    ad = da[ANGLE_W-1] ? -da : da;
    c.big   = (|ax[DIFF_W-1:LIM_W]) | (|ay[DIFF_W-1:LIM_W]);
    c.hturn = ad > {{(ANGLE_W-HLIM_W){1'b0}}, hlim};
    c.sqx   = SQ_W'(ax[LIM_W-1:0]) * SQ_W'(ax[LIM_W-1:0]);
    c.sqy   = SQ_W'(ay[LIM_W-1:0]) * SQ_W'(ay[LIM_W-1:0]);
    c.dx    = dx;
    c.dy    = dy;
    c.turn  = da[TURN_W-1:0];
    return c;
  endfunction

  logic                     s0_valid;
  logic signed [POS_W-1:0]  s0_x;
  logic signed [POS_W-1:0]  s0_y;
  logic signed [HEAD_W-1:0] s0_h;
  logic                     s1_valid;
  logic signed [POS_W-1:0]  s1_x;
  logic signed [POS_W-1:0]  s1_y;
  logic signed [HEAD_W-1:0] s1_h;
  cand_t                    s1_vs_last;
  cand_t                    s1_vs_prev;
  logic signed [POS_W-1:0]  last_x;
  logic signed [POS_W-1:0]  last_y;
  logic signed [HEAD_W-1:0] last_heading;
  logic                     prev_moved;

  cand_t                     sel;
  logic [SQ_W:0]             dist_sq;
  logic                      moved;
  logic signed [ANGLE_W-1:0] h;
  logic                      flip;
  logic [ANGLE_W+11:0]       z_wide;

  // The item ahead has already decided; if it moved, the last pose is its pose.
  always_comb begin
    sel     = prev_moved ? s1_vs_prev : s1_vs_last;
    dist_sq = {1'b0, sel.sqx} + {1'b0, sel.sqy};
    moved   = sel.big | sel.hturn | (dist_sq > {1'b0, lim_sq});
  end

  // Heading folded into [-pi/2, pi/2] for the rotation; cos and sin flip sign.
  always_comb begin
    h    = {{2{s1_h[HEAD_W-1]}}, s1_h};
    flip = 1'b0;
    if (h > PI_Q) h = h - TWO_PI_Q;
    if (h < NEG_PI_Q) h = h + TWO_PI_Q;
    if (h > HALF_PI_Q) begin
      h    = h - PI_Q;
      flip = 1'b1;
    end else if (h < NEG_HALF_PI_Q) begin
      h    = h + PI_Q;
      flip = 1'b1;
    end
    z_wide = {h, 12'b0};
  end

  always_comb begin
    cell_in.valid = s1_valid;
    cell_in.moved = moved;
    cell_in.flip  = flip;
    cell_in.dx    = sel.dx;
    cell_in.dy    = sel.dy;
    cell_in.turn  = sel.turn;
    cell_in.x     = CORDIC_GAIN;
    cell_in.y     = '0;
    cell_in.z     = z_wide[Z_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid     <= 1'b0;
      s1_valid     <= 1'b0;
      prev_moved   <= 1'b0;
      last_x       <= '0;
      last_y       <= '0;
      last_heading <= '0;
    end else if (enable) begin
      s0_valid   <= in_valid;
      s1_valid   <= s0_valid;
      prev_moved <= s1_valid & moved;
      if (s1_valid && moved) begin
        last_x       <= s1_x;
        last_y       <= s1_y;
        last_heading <= s1_h;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      s0_x       <= pose_x;
      s0_y       <= pose_y;
      s0_h       <= pose_heading;
      s1_x       <= s0_x;
      s1_y       <= s0_y;
      s1_h       <= s0_h;
      s1_vs_last <= diff_pose(s0_x, s0_y, s0_h, last_x, last_y, last_heading, heading_limit);
      s1_vs_prev <= diff_pose(s0_x, s0_y, s0_h, s1_x, s1_y, s1_h, heading_limit);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/odg_rotate.sv -----
// ============================================================================
// odg_rotate - projection of the displacement into the robot frame
// Multiplies the differences by cos and sin, then rounds, saturates and holds
// the result in the output register.
// ============================================================================
`default_nettype none

module odg_rotate
  import odg_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                enable,
  input  wire odg_cell_t           cell_out,
  output logic                     out_valid,
  output logic                     moved,
  output logic signed [POS_W-1:0]  step_forward,
  output logic signed [POS_W-1:0]  step_lateral,
  output logic signed [TURN_W-1:0] step_turn
);

  localparam int CS_W   = XY_W + 1;
  localparam int PROD_W = DIFF_W + CS_W;
  localparam int PSUM_W = PROD_W + 1;
  localparam int FRAC   = 28;
  localparam logic signed [PSUM_W:0] ROUND_HALF = (PSUM_W+1)'(1) <<< (FRAC - 1);
  localparam logic signed [PSUM_W:0] SAT_MAX    = (PSUM_W+1)'(32'h7FFF_FFFF);
  localparam logic signed [PSUM_W:0] SAT_MIN    = ~SAT_MAX;

  function automatic logic signed [POS_W-1:0] round_sat(input logic signed [PSUM_W-1:0] p);
    logic signed [PSUM_W:0] r;
    logic signed [PSUM_W:0] q;
    logic signed [POS_W-1:0] v;
    r = (PSUM_W+1)'(p);
    r = r + ROUND_HALF;
    q = r >>> FRAC;
    if (q > SAT_MAX) begin
      v = SAT_MAX[POS_W-1:0];
    end else if (q < SAT_MIN) begin
      v = SAT_MIN[POS_W-1:0];
    end else begin
      v = q[POS_W-1:0];
    end
    return v;
  endfunction

  logic signed [CS_W-1:0]   c;
  logic signed [CS_W-1:0]   s;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;

  logic                     p_valid;
  logic                     p_moved;
  logic signed [TURN_W-1:0] p_turn;
  logic signed [PROD_W-1:0] p_dxc;
  logic signed [PROD_W-1:0] p_dys;
  logic signed [PROD_W-1:0] p_dyc;
  logic signed [PROD_W-1:0] p_dxs;

  logic signed [PSUM_W-1:0] fwd_sum;
  logic signed [PSUM_W-1:0] lat_sum;
  logic signed [PSUM_W-1:0] t0;
  logic signed [PSUM_W-1:0] t1;

  always_comb begin
    c  = CS_W'(cell_out.x);
    s  = CS_W'(cell_out.y);
    dx = cell_out.dx;
    dy = cell_out.dy;
    if (cell_out.flip) begin
      c = -c;
      s = -s;
    end
  end

  always_comb begin
    t0      = PSUM_W'(p_dxc);
    t1      = PSUM_W'(p_dys);
    fwd_sum = t0 + t1;
    t0      = PSUM_W'(p_dyc);
    t1      = PSUM_W'(p_dxs);
    lat_sum = t0 - t1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (enable) begin
      p_valid   <= cell_out.valid;
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      p_moved <= cell_out.moved;
      p_turn  <= cell_out.turn;
      p_dxc   <= PROD_W'(dx) * PROD_W'(c);
      p_dys   <= PROD_W'(dy) * PROD_W'(s);
      p_dyc   <= PROD_W'(dy) * PROD_W'(c);
      p_dxs   <= PROD_W'(dx) * PROD_W'(s);
      moved   <= p_moved;
      if (p_moved) begin
        step_forward <= round_sat(fwd_sum);
        step_lateral <= round_sat(lat_sum);
        step_turn    <= p_turn;
      end else begin
        step_forward <= '0;
        step_lateral <= '0;
        step_turn    <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/odometry_displacement_gate.sv -----
// ============================================================================
// odometry_displacement_gate - odometry update gate on distance and heading
// Passes an odometry step on only when the robot has moved or turned far
// enough, and reports that step in the robot frame.
// ============================================================================
// The block takes one pose (x, y in Q16.16 metres, heading in Q4.12 radians)
// per transaction and returns exactly one result transaction for each, in
// order. It keeps the last pose that counted as a move (zero after reset).
// When the planar distance to that pose exceeds distance_limit, or the wrapped
// heading change exceeds heading_limit, the new pose is kept, tuser reports
// moved=1 and tdata carries the displacement rotated into the robot frame of
// the new heading together with the heading change; otherwise all three steps
// are zero. The block accepts one pose every clock cycle unless the output
// is stalled; each result passes the gate's input registers, the rotation
// cells, the product stage and the output register. The move decision
// is taken inside a single pipeline stage: every pose is compared in advance
// both against the stored last pose and against the pose just ahead of it, so
// the decision of one pose is known in time for the next. The cosine and sine
// of the heading come out of a chain of CORDIC cells, one per pipeline stage,
// followed by a product stage and the output register, which rounds and
// saturates the two sums on the way in. The whole pipeline moves when the
// output register is empty or its result is being taken, so a stalled result
// holds everything behind it in place. Limits should be written through the
// configuration port only while no pose is in flight.
// ============================================================================
`default_nettype none

module odometry_displacement_gate
  import odg_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,

  // Pose stream. tdata: pose_x [31:0], pose_y [63:32], pose_heading [79:64].
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [79:0]            s_axis_tdata,

  // Step stream. tdata: step_forward [31:0], step_lateral [63:32],
  // step_turn [80:64], zero fill [87:81]. tuser: moved [0].
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [87:0]                 m_axis_tdata,
  output logic                        m_axis_tuser,

  // Limit register writes.
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [LIM_W-1:0]  distance_limit;
  logic [HLIM_W-1:0] heading_limit;
  logic [SQ_W-1:0]   lim_sq;
  logic              enable;

  odg_cell_t chain [CELLS+1];

  logic                     moved;
  logic signed [POS_W-1:0]  step_forward;
  logic signed [POS_W-1:0]  step_lateral;
  logic signed [TURN_W-1:0] step_turn;

  // The pipeline advances whenever the output register can take a result.
  assign enable        = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = enable;
  assign cfg_ready     = 1'b1;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_limit <= DISTANCE_LIMIT_RESET;
      heading_limit  <= HEADING_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DISTANCE_LIMIT: distance_limit <= cfg_data[LIM_W-1:0];
        REG_HEADING_LIMIT:  heading_limit  <= cfg_data[HLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Squared distance limit, so the move test needs no square root. It is
  // registered and settles before any newly accepted pose reaches the test.
  always_ff @(posedge clk) begin
    lim_sq <= SQ_W'(distance_limit) * SQ_W'(distance_limit);
  end

  odg_gate u_gate (
    .clk           (clk),
    .rst           (rst),
    .enable        (enable),
    .in_valid      (s_axis_tvalid),
    .pose_x        (s_axis_tdata[31:0]),
    .pose_y        (s_axis_tdata[63:32]),
    .pose_heading  (s_axis_tdata[79:64]),
    .lim_sq        (lim_sq),
    .heading_limit (heading_limit),
    .cell_in       (chain[0])
  );

  // One rotation cell per stage; cell i shifts by i and uses atan(2^-i).
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    odg_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .enable (enable),
      .stage  (STAGE_W'(i)),
      .cin    (chain[i]),
      .cout   (chain[i+1])
    );
  end

  odg_rotate u_rotate (
    .clk          (clk),
    .rst          (rst),
    .enable       (enable),
    .cell_out     (chain[CELLS]),
    .out_valid    (m_axis_tvalid),
    .moved        (moved),
    .step_forward (step_forward),
    .step_lateral (step_lateral),
    .step_turn    (step_turn)
  );

  assign m_axis_tdata = {7'b0, step_turn, step_lateral, step_forward};
  assign m_axis_tuser = moved;

endmodule

`default_nettype wire

// ----- tb/odometry_displacement_gate_tb.sv -----
// ============================================================================
// odometry_displacement_gate_tb - self-checking bench for the odometry gate
// Drives pose transactions through the block while it tracks the last stored
// pose, the limits and the robot-frame step on its own, and compares every
// step transaction field by field, in order, under changing stream pressure.
// ============================================================================

module odometry_displacement_gate_tb
  import odg_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Upper bound on the whole run. It lies far above the length of any correct
  // run, so this only trips on a hang.
  localparam int CYCLE_LIMIT = 400000;
  // Pose-to-step latency plus some margin, used when letting the block settle.
  localparam int SETTLE_CYCLES = CELLS + 12;
  // Number of random poses sent under each limit setting (eight settings).
  localparam int POSES_PER_SETTING = 119;
  localparam int MAX_PRINTED = 40;

  localparam int POS_MAX = 32'sh7FFF_FFFF;
  localparam int POS_MIN = 32'sh8000_0000;
  localparam longint UNSIGNED_LIM_MAX = 64'h7FFF_FFFF;

  // One expected step transaction.
  typedef struct {
    logic                     moved;
    logic signed [POS_W-1:0]  forward;
    logic signed [POS_W-1:0]  lateral;
    logic signed [TURN_W-1:0] turn;
  } step_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the block's pins. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // Fields from bit 0 up: pose_x [31:0], pose_y [63:32], pose_heading [79:64].
  logic [79:0]            s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // Fields from bit 0 up: step_forward [31:0], step_lateral [63:32],
  // step_turn [80:64], zero fill [87:81].
  logic [87:0]            m_axis_tdata;
  // Fields from bit 0 up: moved [0].
  logic                   m_axis_tuser;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;

  odometry_displacement_gate u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Bench-side copy of the block's state: the stored pose and both limits.
  // --------------------------------------------------------------------------
  int                stored_x       = 0;
  int                stored_y       = 0;
  shortint           stored_heading = 0;
  logic [LIM_W-1:0]  dist_limit     = DISTANCE_LIMIT_RESET;
  logic [HLIM_W-1:0] turn_limit     = HEADING_LIMIT_RESET;

  step_t expected_steps[$];
  int    error_count   = 0;
  int    cycle_count   = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  // --------------------------------------------------------------------------
  // Step prediction.
  // --------------------------------------------------------------------------

  // Arctangent of 2^-i in Q.24 for the rotation chain.
  function automatic longint atan_step(input int i);
    case (i)
      0:  return 13176795;
      1:  return 7778716;
      2:  return 4110060;
      3:  return 2086331;
      4:  return 1047214;
      5:  return 524117;
      6:  return 262123;
      7:  return 131069;
      default: return (i < 24) ? (longint'(1) << (24 - i)) : 0;
    endcase
  endfunction

  // Cosine and sine of a heading in Q.28. The heading is folded once into
  // [-pi, pi]; beyond a quarter turn it is moved by pi and both results are
  // negated, so the CORDIC chain only sees angles inside [-pi/2, pi/2].
  function automatic void heading_cos_sin(input longint heading, output longint c,
                                          output longint s);
    longint x;
    longint y;
    longint z;
    longint nx;
    logic   flip;
    x = CORDIC_GAIN;
    y = 0;
    flip = 1'b0;
    if (heading > longint'(PI_Q)) heading -= longint'(TWO_PI_Q);
    if (heading < -longint'(PI_Q)) heading += longint'(TWO_PI_Q);
    if (heading > longint'(HALF_PI_Q)) begin
      heading -= longint'(PI_Q);
      flip = 1'b1;
    end else if (heading < -longint'(HALF_PI_Q)) begin
      heading += longint'(PI_Q);
      flip = 1'b1;
    end
    z = heading * 4096;
    for (int i = 0; i < ROTATION_STAGES && i < 24; i++) begin
      // Arithmetic shifts of signed values round toward minus infinity.
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_step(i);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_step(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Q16.16 times Q.28 back to Q16.16, rounded half up and clamped.
  function automatic logic signed [POS_W-1:0] round_saturate(input longint product);
    longint q;
    q = (product + 64'sd134217728) >>> 28;
    if (q > longint'(POS_MAX)) q = POS_MAX;
    if (q < longint'(POS_MIN)) q = POS_MIN;
    return q[POS_W-1:0];
  endfunction

  // Works out the step transaction of one pose and moves the stored pose on
  // when the pose counts as a move.
  function automatic step_t predict_step(input int px, input int py, input shortint ph);
    longint          dx;
    longint          dy;
    longint          da;
    longint          c;
    longint          s;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned ad;
    longint unsigned lim;
    logic            moved;
    step_t           step;
    dx = longint'(px) - longint'(stored_x);
    dy = longint'(py) - longint'(stored_y);
    da = longint'(ph) - longint'(stored_heading);
    if (da > longint'(PI_Q)) da -= longint'(TWO_PI_Q);
    if (da < -longint'(PI_Q)) da += longint'(TWO_PI_Q);
    ax  = (dx < 0) ? -dx : dx;
    ay  = (dy < 0) ? -dy : dy;
    ad  = (da < 0) ? -da : da;
    lim = dist_limit;
    // A difference too large for a 31-bit magnitude always counts as a move;
    // otherwise the squared distance is compared exactly.
    if (ax > UNSIGNED_LIM_MAX || ay > UNSIGNED_LIM_MAX) moved = 1'b1;
    else moved = (ax * ax + ay * ay) > (lim * lim);
    if (ad > turn_limit) moved = 1'b1;
    step.moved   = moved;
    step.forward = '0;
    step.lateral = '0;
    step.turn    = '0;
    if (!moved) return step;
    heading_cos_sin(longint'(ph), c, s);
    step.forward = round_saturate(dx * c + dy * s);
    step.lateral = round_saturate(dy * c - dx * s);
    step.turn    = da[TURN_W-1:0];
    stored_x       = px;
    stored_y       = py;
    stored_heading = ph;
    return step;
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting and the result checker.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Every step transaction is taken at the rising edge and compared with the
  // oldest expectation. Values are read before the edge's updates land.
  always @(posedge clk) begin : check_steps
    step_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_steps.size() == 0) begin
        report_mismatch("unexpected step transaction", 0, 0);
      end else begin
        want = expected_steps.pop_front();
        if (m_axis_tuser !== want.moved)
          report_mismatch("moved", longint'(m_axis_tuser), longint'(want.moved));
        if ($signed(m_axis_tdata[31:0]) !== want.forward)
          report_mismatch("step_forward", longint'($signed(m_axis_tdata[31:0])),
                          longint'(want.forward));
        if ($signed(m_axis_tdata[63:32]) !== want.lateral)
          report_mismatch("step_lateral", longint'($signed(m_axis_tdata[63:32])),
                          longint'(want.lateral));
        if ($signed(m_axis_tdata[80:64]) !== want.turn)
          report_mismatch("step_turn", longint'($signed(m_axis_tdata[80:64])),
                          longint'(want.turn));
      end
    end
  end

  // The receiver holds off at random; the stall rate changes per phase.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------

  // Sends one pose. Inputs change at the falling edge; tvalid is left high
  // after the transaction so back-to-back poses never drop it in between.
  task automatic send_pose(input int px, input int py, input shortint ph);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ph, py, px};
    do @(posedge clk); while (!s_axis_tready);
    expected_steps.push_back(predict_step(px, py, ph));
  endtask

  // Writes one limit register and mirrors it. Indexes outside the register
  // list and value bits above the register width are dropped by the block.
  task automatic write_limit(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      REG_DISTANCE_LIMIT: dist_limit = value[LIM_W-1:0];
      REG_HEADING_LIMIT:  turn_limit = value[HLIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drops tvalid, then waits until every expected step has come back and the
  // pipeline has had time to run dry. Limits are only written after this.
  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Keeps a heading inside plus or minus two pi by two turns.
  function automatic shortint fold_heading(input longint h);
    if (h > longint'(TWO_PI_Q)) h -= 2 * longint'(TWO_PI_Q);
    if (h < -longint'(TWO_PI_Q)) h += 2 * longint'(TWO_PI_Q);
    return shortint'(h);
  endfunction

  // Random pose, mostly relative to the stored pose so that the thresholds
  // are hit often: repeats, steps around the limits, poses right on the
  // limits and a share of fully random poses.
  task automatic send_random_pose();
    longint x;
    longint y;
    longint h;
    longint span;
    longint hspan;
    longint sgn;
    int     kind;
    kind  = $urandom_range(99);
    span  = 2 * longint'(dist_limit) + 8;
    hspan = 2 * longint'(turn_limit) + 4;
    if (span > 64'd2147483648) span = 64'd2147483648;
    sgn   = ($urandom_range(1) == 0) ? 1 : -1;
    x = stored_x;
    y = stored_y;
    h = stored_heading;
    if (kind < 15) begin
      // Same pose again, nothing should move.
    end else if (kind < 55) begin
      x = x + longint'($urandom_range(0, span)) - span / 2;
      y = y + longint'($urandom_range(0, span)) - span / 2;
      h = h + longint'($urandom_range(0, hspan)) - hspan / 2;
    end else if (kind < 75) begin
      // On the edge of one limit: one below, equal or one above.
      if ($urandom_range(1) == 0) begin
        if ($urandom_range(1) == 0)
          x = x + sgn * (longint'(dist_limit) + longint'($urandom_range(2)) - 1);
        else
          y = y + sgn * (longint'(dist_limit) + longint'($urandom_range(2)) - 1);
      end else begin
        h = h + sgn * (longint'(turn_limit) + longint'($urandom_range(2)) - 1);
      end
    end else begin
      x = $signed($urandom);
      y = $signed($urandom);
      h = longint'($urandom_range(0, 2 * TWO_PI_Q)) - longint'(TWO_PI_Q);
    end
    send_pose(int'(x), int'(y), fold_heading(h));
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Reset limits: both thresholds at and just past their edges, the heading
  // wrap, every quadrant of the rotation and the extremes of the positions.
  task automatic test_directed_poses();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_pose(0, 0, 0);                 // no change at all
    send_pose(13107, 0, 0);             // distance equal to the limit
    send_pose(9000, -9000, 0);          // diagonal still inside the limit
    send_pose(13108, 0, 0);             // one past the limit
    send_pose(13108, 0, 819);           // turn equal to the limit
    send_pose(13108, 0, 820);           // turn one past the limit
    send_pose(13108, 0, 12800);
    send_pose(13108, 0, -12800);        // large raw change that wraps to a small one
    send_pose(13108, 0, -12000);        // wraps to a change above the limit
    send_pose(113108, 50000, 6434);     // exactly a quarter turn, no fold
    send_pose(213108, -50000, 6435);    // just past a quarter turn, folded
    send_pose(113108, 50000, -6435);
    send_pose(13108, 150000, -6434);
    send_pose(POS_MAX, POS_MAX, 25736); // huge difference, saturated steps
    send_pose(POS_MIN, POS_MIN, -25736);
    send_pose(POS_MAX, POS_MIN, 0);
    send_pose(0, 0, 0);
  endtask

  // Both registers at their extremes, dropped upper bits, writes to indexes
  // that are not registers, and the reset values written back.
  task automatic test_limit_registers();
    wait_idle();
    write_limit(REG_DISTANCE_LIMIT, 32'd0);
    write_limit(REG_HEADING_LIMIT, 32'd0);
    send_pose(0, 0, 0);                 // zero limits, zero change: no move
    send_pose(1, 0, 0);
    send_pose(1, 0, 1);
    wait_idle();
    // All ones: only the low 31 bits land. Upper bits above the heading
    // register are set too and must be dropped, leaving two pi.
    write_limit(REG_DISTANCE_LIMIT, 32'hFFFF_FFFF);
    write_limit(REG_HEADING_LIMIT, 32'hFFFF_6488);
    send_pose(POS_MAX, 0, -25736);      // large difference that still fits
    send_pose(POS_MIN, 0, 25736);       // magnitude past 31 bits
    send_pose(-1, 0, 25736);            // exactly on the largest limit
    send_pose(0, 0, 25736);
    wait_idle();
    write_limit(REG_DISTANCE_LIMIT, 32'(DISTANCE_LIMIT_RESET));
    write_limit(REG_HEADING_LIMIT, 32'(HEADING_LIMIT_RESET));
    for (int idx = REG_HEADING_LIMIT + 1; idx < (1 << CFG_INDEX_W); idx++)
      write_limit(CFG_INDEX_W'(idx), $urandom);
    send_pose(0, 13108, 25736);
    send_pose(0, 13108, 24917);         // turn back by exactly the limit
  endtask

  // Random traffic in four pressure phases, two random limit settings each.
  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] dist_value;
    logic [CFG_DATA_W-1:0] turn_value;
    for (int phase = 0; phase < 4; phase++) begin
      for (int setting = 0; setting < 2; setting++) begin
        wait_idle();
        case ($urandom_range(4))
          0:       dist_value = 0;
          1:       dist_value = $urandom_range(1, 65535);
          2:       dist_value = 32'(DISTANCE_LIMIT_RESET);
          3:       dist_value = $urandom_range(65536, 32'h7FFF_FFFF);
          default: dist_value = 32'h7FFF_FFFF;
        endcase
        case ($urandom_range(3))
          0:       turn_value = 0;
          1:       turn_value = $urandom_range(1, 2000);
          2:       turn_value = $urandom_range(2001, TWO_PI_Q);
          default: turn_value = 32'(TWO_PI_Q);
        endcase
        write_limit(REG_DISTANCE_LIMIT, dist_value);
        write_limit(REG_HEADING_LIMIT, turn_value);
        // Phases: free flow, idle sender, stalling receiver, both.
        case (phase)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
          default: begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
        repeat (POSES_PER_SETTING) send_random_pose();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Run sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_poses();
    test_limit_registers();
    test_random_traffic();
    wait_idle();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- odometry_displacement_gate.f -----
hw/rtl/odg_pkg.sv
hw/rtl/odg_cell.sv
hw/rtl/odg_gate.sv
hw/rtl/odg_rotate.sv
hw/rtl/odometry_displacement_gate.sv
tb/odometry_displacement_gate_tb.sv
